[rtl/sis_pkg.sv]
package sis_pkg;

    // field widths of one record
    localparam int KEY_W   = 32;
    localparam int TAG_W   = 16;
    localparam int DATA_W  = 48;
    // record count width, covers a store of up to 127 entries
    localparam int CNT_W   = 7;
    localparam int MAX_RECORDS_DEF = 64;

    // controller to datapath commands
    typedef struct packed {
        logic             insert;
        logic             shift_out;
        logic [CNT_W-1:0] fill;
    } sis_cmd_t;

endpackage

[rtl/sis_ctrl.sv]
module sis_ctrl import sis_pkg::*; #(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     s_tlast,
    output logic     m_tvalid,
    input  logic     m_tready,
    output logic     m_tlast,
    output sis_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             in_beat, out_beat, full;

    assign full     = (fill_reg == CNT_W'(MAX_RECORDS));
    assign s_tready = (state_reg == ST_FILL);
    assign m_tvalid = (state_reg == ST_DRAIN);
    assign m_tlast  = (state_reg == ST_DRAIN) && (fill_reg == CNT_W'(1));
    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // commands to the cell row
    assign cmd.insert    = in_beat && !full;
    assign cmd.shift_out = out_beat;
    assign cmd.fill      = fill_reg;

    // fill count and state sequencing
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        unique case (state_reg)
            ST_FILL: begin
                if (in_beat) begin
                    if (!full) begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    if (s_tlast) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (out_beat) begin
                    fill_next = fill_reg - CNT_W'(1);
                    if (fill_reg == CNT_W'(1)) begin
                        state_next = ST_FILL;
                    end
                end
            end
            default: begin
                state_next = ST_FILL;
                fill_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

[rtl/sis_cells.sv]
module sis_cells import sis_pkg::*; #(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic             aclk,
    input  sis_cmd_t         cmd,
    input  logic [KEY_W-1:0] in_key,
    input  logic [TAG_W-1:0] in_tag,
    output logic [KEY_W-1:0] head_key,
    output logic [TAG_W-1:0] head_tag
);

    logic [KEY_W-1:0] key_reg  [MAX_RECORDS];
    logic [TAG_W-1:0] tag_reg  [MAX_RECORDS];
    logic [KEY_W-1:0] key_next [MAX_RECORDS];
    logic [TAG_W-1:0] tag_next [MAX_RECORDS];
    logic             take     [MAX_RECORDS];

    // a cell takes part in the insert if it holds a larger key or is the first free one
    always_comb begin
        for (int i = 0; i < MAX_RECORDS; i++) begin
            take[i] = ((CNT_W'(i) < cmd.fill) && (key_reg[i] > in_key))
                      || (CNT_W'(i) == cmd.fill);
        end
    end

    // compare-and-shift on insert, shift towards the head on drain
    always_comb begin
        for (int i = 0; i < MAX_RECORDS; i++) begin
            key_next[i] = key_reg[i];
            tag_next[i] = tag_reg[i];
            if (cmd.insert) begin
                if (i > 0 && take[(i > 0) ? i - 1 : 0]) begin
                    key_next[i] = key_reg[(i > 0) ? i - 1 : 0];
                    tag_next[i] = tag_reg[(i > 0) ? i - 1 : 0];
                end else if (take[i]) begin
                    key_next[i] = in_key;
                    tag_next[i] = in_tag;
                end
            end else if (cmd.shift_out && (i < MAX_RECORDS - 1)) begin
                key_next[i] = key_reg[(i < MAX_RECORDS - 1) ? i + 1 : i];
                tag_next[i] = tag_reg[(i < MAX_RECORDS - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RECORDS; i++) begin
            key_reg[i] <= key_next[i];
            tag_reg[i] <= tag_next[i];
        end
    end

    assign head_key = key_reg[0];
    assign head_tag = tag_reg[0];

endmodule

[rtl/stable_insertion_sorter_core.sv]
// latency: a record is placed in the cell row in the cycle it is accepted
// throughput: one record per cycle while collecting; a stored set of n records drains
// in n beats from the head of the row, one per cycle while m_tready is high, during which no input is taken
// the compare-and-shift row, 64 cells by default, performs the insert
// reset (aresetn low, synchronous) empties the store and returns to collecting
module stable_insertion_sorter_core import sis_pkg::*; #(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // key [31:0], tag [47:32]
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // key_out [31:0], tag_out [47:32]
    output logic              m_tlast
);

    sis_cmd_t         cmd;
    logic [KEY_W-1:0] head_key;
    logic [TAG_W-1:0] head_tag;

    // sequencing of collect and drain phases
    sis_ctrl #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .cmd      (cmd)
    );

    // sorted cell row
    sis_cells #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_cells (
        .aclk     (aclk),
        .cmd      (cmd),
        .in_key   (s_tdata[KEY_W-1:0]),
        .in_tag   (s_tdata[KEY_W +: TAG_W]),
        .head_key (head_key),
        .head_tag (head_tag)
    );

    assign m_tdata = {head_tag, head_key};

endmodule
